[src/me_pkg.sv]
// Package for the modular exponentiation block: operand widths, counter
// widths and the state types of both sequencers. No dependencies.
package me_pkg;

  localparam int OPERAND_BITS  = 31;
  localparam int EXPONENT_BITS = 63;
  localparam int CNT_W         = (OPERAND_BITS > 1) ? $clog2(OPERAND_BITS) : 1;

  typedef logic [OPERAND_BITS-1:0]  operand_t;
  typedef logic [EXPONENT_BITS-1:0] exponent_t;

  // Modular multiplier sequencer.
  typedef enum logic [1:0] {
    MM_IDLE,
    MM_DBL,
    MM_ADD,
    MM_DONE
  } mm_state_t;

  // Status the multiplier reports to the exponent sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

  // Exponent sequencer.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_BIT,
    ST_MUL_ACC,
    ST_MUL_SQ,
    ST_FINISH
  } top_state_t;

endpackage

[src/me_mulmod.sv]
// Shared modular multiplier: x * y mod m by interleaved double-and-add,
// one multiplier bit per pass through its double and add states. Depends on me_pkg.
module me_mulmod
  import me_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  operand_t x,
  input  operand_t y,
  input  operand_t m,
  output mm_stat_t stat,
  output operand_t result
);

  mm_state_t        state_r, state_nxt;
  operand_t         r_r, x_r, y_r, m_r;
  logic [CNT_W-1:0] cnt_r;
  logic             load;
  logic             last_bit;

  logic [OPERAND_BITS:0] dbl_w, dbl_red, sum_w, sum_red;

  // Both intermediate values stay below 2m, so one conditional subtract
  // brings each back into range.
  assign dbl_w   = {r_r, 1'b0};
  assign dbl_red = (dbl_w >= {1'b0, m_r}) ? (dbl_w - {1'b0, m_r}) : dbl_w;
  assign sum_w   = {1'b0, r_r} + {1'b0, x_r};
  assign sum_red = (sum_w >= {1'b0, m_r}) ? (sum_w - {1'b0, m_r}) : sum_w;
  assign last_bit = (cnt_r == CNT_W'(OPERAND_BITS - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      MM_IDLE: begin
        if (start) state_nxt = MM_DBL;
      end
      MM_DBL: state_nxt = MM_ADD;
      MM_ADD: begin
        state_nxt = last_bit ? MM_DONE : MM_DBL;
      end
      MM_DONE: begin
        state_nxt = start ? MM_DBL : MM_IDLE;
      end
      default: state_nxt = MM_IDLE;
    endcase
  end

  always_comb begin
    stat.busy = 1'b0;
    stat.done = 1'b0;
    load      = 1'b0;
    case (state_r)
      MM_IDLE: load = start;
      MM_DBL,
      MM_ADD:  stat.busy = 1'b1;
      MM_DONE: begin
        stat.done = 1'b1;
        load      = start;
      end
      default: stat.busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_r   <= x;
      y_r   <= y;
      m_r   <= m;
      r_r   <= '0;
      cnt_r <= '0;
    end else if (state_r == MM_DBL) begin
      r_r <= dbl_red[OPERAND_BITS-1:0];
    end else if (state_r == MM_ADD) begin
      if (y_r[OPERAND_BITS-1]) r_r <= sum_red[OPERAND_BITS-1:0];
      y_r   <= {y_r[OPERAND_BITS-2:0], 1'b0};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign result = r_r;

`ifndef ASSERT_OFF
  a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> (r_r < m_r))
    else $error("multiplier result not below modulus");

  a_partial_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy |-> (r_r < m_r))
    else $error("partial remainder left the residue range");

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == MM_ADD && last_bit) |=> stat.done)
    else $error("multiplier did not finish after its last bit");
`endif

endmodule

[src/modular_exponentiation_top.sv]
// Time from input beat to result beat grows with the position of the highest set exponent bit
// and with the number of set bits, since every product runs through the one shared 31-bit
// multiplier; a zero modulus bypasses the multiplier altogether.
// Throughput: one item at a time; in_ready is high only while the sequencer is idle.
// Reset (synchronous, rst_n low) clears both sequencers and the result valid flag.
// Top level of the modular exponentiation block. Depends on me_pkg and me_mulmod.
module modular_exponentiation_top
  import me_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  operand_t  in_base_value,
  input  exponent_t in_exponent,
  input  operand_t  in_modulus,
  output logic      out_valid,
  input  logic      out_ready,
  output operand_t  out_power_residue
);

  // Right-to-left square-and-multiply. Every modular product, including the
  // initial reduction of the base (computed as (1 mod m) * base), runs through
  // the single shared multiplier.

  top_state_t state_r, state_nxt;
  operand_t   acc_r, sq_r, m_r;
  exponent_t  exp_r;
  logic       out_valid_r;
  operand_t   out_data_r;

  logic       mm_start;
  operand_t   mm_x, mm_y, mm_m, mm_result;
  mm_stat_t   mm_stat;

  logic       accept;
  logic       zero_mod;
  logic       exp_rest_zero;
  logic       out_free;
  operand_t   one_mod;

  assign accept        = in_valid && in_ready;
  assign zero_mod      = (in_modulus == '0);
  // 1 mod m is 0 only for a modulus of one.
  assign one_mod       = (in_modulus == operand_t'(1)) ? '0 : operand_t'(1);
  assign exp_rest_zero = ((exp_r >> 1) == '0);
  // The result register can take a new beat when it is empty or being drained.
  assign out_free      = !out_valid_r || out_ready;

  // Next state of the exponent sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = zero_mod ? ST_BIT : ST_REDUCE;
      end
      ST_REDUCE: begin
        if (mm_stat.done) state_nxt = ST_BIT;
      end
      ST_BIT: begin
        if (exp_r == '0)     state_nxt = ST_FINISH;
        else if (exp_r[0])   state_nxt = ST_MUL_ACC;
        else                 state_nxt = ST_MUL_SQ;
      end
      ST_MUL_ACC: begin
        if (mm_stat.done) state_nxt = exp_rest_zero ? ST_BIT : ST_MUL_SQ;
      end
      ST_MUL_SQ: begin
        if (mm_stat.done) state_nxt = ST_BIT;
      end
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake and multiplier operand selection.
  always_comb begin
    in_ready = 1'b0;
    mm_start = 1'b0;
    mm_x     = sq_r;
    mm_y     = sq_r;
    mm_m     = m_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        mm_start = in_valid && !zero_mod;
        mm_x     = one_mod;
        mm_y     = in_base_value;
        mm_m     = in_modulus;
      end
      ST_BIT: begin
        mm_start = (exp_r != '0);
        mm_x     = exp_r[0] ? acc_r : sq_r;
      end
      ST_MUL_ACC: begin
        // Square right after the multiply unless no exponent bits remain.
        mm_start = mm_stat.done && !exp_rest_zero;
      end
      default: mm_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Working registers of the exponent loop.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          m_r   <= in_modulus;
          acc_r <= zero_mod ? '0 : one_mod;
          exp_r <= zero_mod ? '0 : in_exponent;
        end
      end
      ST_REDUCE: begin
        if (mm_stat.done) sq_r <= mm_result;
      end
      ST_MUL_ACC: begin
        if (mm_stat.done) begin
          acc_r <= mm_result;
          if (exp_rest_zero) exp_r <= '0;
        end
      end
      ST_MUL_SQ: begin
        if (mm_stat.done) begin
          sq_r  <= mm_result;
          exp_r <= exp_r >> 1;
        end
      end
      default: acc_r <= acc_r;
    endcase
  end

  // Output register: the result beat waits here while the block goes idle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FINISH && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FINISH && out_free) out_data_r <= acc_r;
  end

  assign out_valid         = out_valid_r;
  assign out_power_residue = out_data_r;

  me_mulmod u_mulmod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mm_start),
    .x      (mm_x),
    .y      (mm_y),
    .m      (mm_m),
    .stat   (mm_stat),
    .result (mm_result)
  );

`ifndef ASSERT_OFF
  a_idle_mul_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mm_stat.busy)
    else $error("multiplier busy while the sequencer is idle");

  a_acc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BIT && m_r != '0) |-> (acc_r < m_r && sq_r < m_r))
    else $error("loop operand not reduced by the modulus");

  a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && out_free) |=> (out_valid_r && out_data_r == $past(acc_r)))
    else $error("finished result not placed in the output register");
`endif

endmodule

[tb/sv/modular_exponentiation_top_tb.sv]
// Self-checking testbench for modular_exponentiation_top: directed and random
// exponentiations are checked against a local square-and-multiply predictor.
// Depends on me_pkg and the modular_exponentiation_top RTL.
`timescale 1ns / 100ps

module modular_exponentiation_top_tb;
  import me_pkg::*;

  localparam operand_t  OPERAND_MAX  = '1;
  localparam exponent_t EXPONENT_MAX = '1;
  // A prime just under 2^31; keeps the residues spread over the full width.
  localparam operand_t  BIG_PRIME    = 31'd2147483647;
  localparam int        LONG_HOLD    = 2500;

  // One accepted input beat together with the residue it must produce.
  typedef struct {
    operand_t  base_value;
    exponent_t exponent;
    operand_t  modulus;
    operand_t  residue;
  } power_job_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  operand_t  in_base_value;
  exponent_t in_exponent;
  operand_t  in_modulus;
  logic      out_valid;
  logic      out_ready;
  operand_t  out_power_residue;

  // Residues still owed by the block, oldest first.
  power_job_t pending_jobs[$];

  int  error_count     = 0;
  int  items_sent      = 0;
  int  results_checked = 0;
  int  full_exponents  = 0;
  // While set, neither side inserts idle cycles.
  bit  steady_mode     = 1'b0;
  // A one-shot request for the result side to hold off for this many cycles.
  int  out_hold_cycles = 0;

  modular_exponentiation_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_base_value     (in_base_value),
    .in_exponent       (in_exponent),
    .in_modulus        (in_modulus),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_power_residue (out_power_residue)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Right-to-left square-and-multiply. Operands stay below 2^31, so every
  // product fits in 64 bits. A zero modulus is out of range and answers zero.
  function automatic operand_t predict_residue(operand_t base_v, exponent_t exp_v,
                                               operand_t mod_v);
    logic [63:0] running;
    logic [63:0] square;
    logic [63:0] mod_wide;
    exponent_t   bits_left;
    if (mod_v == '0) return '0;
    mod_wide  = 64'(mod_v);
    running   = 64'd1 % mod_wide;
    square    = 64'(base_v) % mod_wide;
    bits_left = exp_v;
    while (bits_left != '0) begin
      if (bits_left[0]) running = (running * square) % mod_wide;
      bits_left = bits_left >> 1;
      square    = (square * square) % mod_wide;
    end
    return operand_t'(running);
  endfunction

  // Most exponents are short so the run stays quick; some span 13 to 40 bits
  // and about one in eight uses all 63 bits.
  function automatic exponent_t rand_exponent();
    int        pick;
    exponent_t value;
    pick  = $urandom_range(0, 99);
    value = exponent_t'({$urandom, $urandom});
    if (pick < 70) begin
      value = value & ((exponent_t'(1) << $urandom_range(1, 12)) - 1);
    end else if (pick < 88) begin
      value = value & ((exponent_t'(1) << $urandom_range(13, 40)) - 1);
    end
    return value;
  endfunction

  function automatic operand_t rand_modulus();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) return '0;
    if (pick < 9) return operand_t'(1);
    if (pick < 14) return OPERAND_MAX;
    if (pick < 45) return operand_t'($urandom_range(2, 1000));
    return operand_t'($urandom);
  endfunction

  function automatic operand_t rand_base();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return operand_t'($urandom_range(0, 1));
    if (pick < 20) return OPERAND_MAX;
    if (pick < 40) return operand_t'($urandom_range(2, 5000));
    return operand_t'($urandom);
  endfunction

  // Offers one input beat after a random gap and returns once it is taken.
  // Valid is left high on return; the next call either keeps it high for a
  // back-to-back beat or lowers it for a gap, so it changes once per edge.
  task automatic send_power(input operand_t base_v, input exponent_t exp_v,
                            input operand_t mod_v);
    int         gap;
    power_job_t job;
    gap = steady_mode ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_base_value <= base_v;
    in_exponent   <= exp_v;
    in_modulus    <= mod_v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    job.base_value = base_v;
    job.exponent   = exp_v;
    job.modulus    = mod_v;
    job.residue    = predict_residue(base_v, exp_v, mod_v);
    pending_jobs.push_back(job);
    items_sent++;
    if (exp_v[EXPONENT_BITS-1]) full_exponents++;
  endtask

  // Drops valid and waits for every owed residue to come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_jobs.size() != 0) @(posedge clk);
  endtask

  // A zero exponent gives 1 mod modulus, which is 0 only for a modulus of one.
  task automatic test_zero_exponent();
    send_power(31'd5, '0, 31'd7);
    send_power('0, '0, 31'd13);
    send_power(OPERAND_MAX, '0, OPERAND_MAX);
    send_power(31'd123, '0, 31'd1);
    drain_results();
  endtask

  // With a modulus of one every residue is zero, whatever the other fields.
  task automatic test_modulus_one();
    send_power(OPERAND_MAX, 63'h1234_5678_9abc, 31'd1);
    send_power('0, 63'd5, 31'd1);
    drain_results();
  endtask

  // A zero modulus is out of range; the block must still answer zero.
  task automatic test_zero_modulus();
    send_power(31'd7, 63'd3, '0);
    send_power(OPERAND_MAX, EXPONENT_MAX, '0);
    drain_results();
  endtask

  // Bases at or above the modulus must be reduced before squaring.
  task automatic test_unreduced_base();
    send_power(31'd1000, 63'd13, 31'd7);
    send_power(OPERAND_MAX, 63'd5, 31'd3);
    send_power(31'd97, 63'd4, 31'd97);
    drain_results();
  endtask

  // An all-zero base, all-one fields, a lone top exponent bit and the slowest item
  // (every exponent bit set), so every input bit takes both values.
  task automatic test_field_extremes();
    send_power('0, 63'd1, OPERAND_MAX);
    send_power(OPERAND_MAX, 63'd1, OPERAND_MAX);
    send_power(OPERAND_MAX, EXPONENT_MAX, BIG_PRIME - 31'd1);
    send_power(31'd3, exponent_t'(1) << (EXPONENT_BITS - 1), 31'd1000003);
    send_power(31'd2, EXPONENT_MAX, BIG_PRIME);
    send_power(31'd1, EXPONENT_MAX, 31'd1000);
    drain_results();
  endtask

  // Random items; a middle stretch runs with no idle cycles on either side.
  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      steady_mode = (i >= count / 3) && (i < count / 3 + 20);
      send_power(rand_base(), rand_exponent(), rand_modulus());
    end
    steady_mode = 1'b0;
    drain_results();
  endtask

  // The result side holds off for a long stretch after the first residue, so a
  // finished residue sits unread while the sender keeps offering beats and the
  // input has to stall behind it.
  task automatic test_output_backpressure();
    out_hold_cycles = LONG_HOLD;
    for (int i = 0; i < 6; i++) begin
      send_power(rand_base(), exponent_t'($urandom_range(1, 255)),
                 operand_t'($urandom_range(2, 100000)));
    end
    drain_results();
  endtask

  // Result side: draws a stall before each beat, or takes a pending long hold.
  // Ready stays high across back-to-back beats so it is assigned once per edge.
  initial begin : result_sink
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (out_hold_cycles > 0) begin
        stall           = out_hold_cycles;
        out_hold_cycles = 0;
      end else begin
        stall = steady_mode ? 0 : $urandom_range(0, 10);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Every result beat is matched against the oldest owed residue.
  always @(posedge clk) begin : check_results
    power_job_t job;
    if (rst_n && out_valid && out_ready) begin
      if (pending_jobs.size() == 0) begin
        $error("power_residue beat with nothing pending: actual %0h", out_power_residue);
        error_count++;
      end else begin
        job = pending_jobs.pop_front();
        results_checked++;
        if (out_power_residue !== job.residue) begin
          $error("power_residue mismatch for %0h^%0h mod %0h: expected %0h, actual %0h",
                 job.base_value, job.exponent, job.modulus, job.residue,
                 out_power_residue);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_base_value <= '0;
    in_exponent   <= '0;
    in_modulus    <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_exponent();
    test_modulus_one();
    test_zero_modulus();
    test_unreduced_base();
    test_field_extremes();
    test_random(77);
    test_output_backpressure();

    // Nothing is owed now; a quiet stretch catches any stray result beat.
    repeat (100) @(posedge clk);
    if (pending_jobs.size() != 0) begin
      $error("%0d power_residue beats never arrived", pending_jobs.size());
      error_count++;
    end

    $display("Ran %0d exponentiations (%0d with 63-bit exponents), %0d residues checked,",
             items_sent, full_exponents, results_checked);
    $display("covering zero exponent and modulus, modulus one, unreduced bases and stalls.");
    if (error_count == 0) begin
      $display("modular_exponentiation_top_tb passed");
    end else begin
      $display("modular_exponentiation_top_tb failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest correct run.
  initial begin
    #60_000_000;
    $display("modular_exponentiation_top_tb failed");
    $finish;
  end

endmodule
